### rtl/wmpc_pkg.sv
// Shared types and constants for the window motor position controller.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps

package wmpc_pkg;

   localparam logic [2:0] REQ_TICK      = 3'd0;
   localparam logic [2:0] REQ_SET_TGT   = 3'd1;
   localparam logic [2:0] REQ_OPEN      = 3'd2;
   localparam logic [2:0] REQ_CLOSE     = 3'd3;
   localparam logic [2:0] REQ_CALIBRATE = 3'd4;

   localparam logic [23:0] TIMEOUT_RESET  = 24'd500000;
   localparam logic [23:0] TRAVEL_RESET   = 24'd180000;
   localparam logic [17:0] TRAVEL_Q_RESET = 18'd1800;
   localparam logic [6:0]  PCT_FULL       = 7'd100;
   localparam logic [6:0]  PCT_ZERO       = 7'd0;

   // floor(x / 100) = (x * DIV100_MAGIC) >> DIV100_SHIFT for any 24-bit x
   localparam logic [24:0] DIV100_MAGIC = 25'd21474837;
   localparam int          DIV100_SHIFT = 31;

   typedef enum logic [2:0] {
      PH_IDLE        = 3'd0,
      PH_OPEN        = 3'd1,
      PH_CLOSE       = 3'd2,
      PH_INIT_CLOSE  = 3'd3,
      PH_CAL_CLOSE   = 3'd4,
      PH_CAL_OPEN    = 3'd5,
      PH_CAL_RECLOSE = 3'd6,
      PH_ERROR       = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      DRV_RELEASE = 2'd0,
      DRV_CLOSE   = 2'd1,
      DRV_OPEN    = 2'd2
   } drive_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic [6:0] target_percent;
      logic       open_switch;
      logic       close_switch;
   } wmpc_req_type;

   typedef struct packed {
      logic [1:0]  motor_drive;
      logic [6:0]  position_percent;
      logic        position_known;
      logic [2:0]  phase;
      logic        calibrating;
      logic [23:0] full_travel_ms;
   } wmpc_rsp_type;

endpackage

### rtl/wmpc_in_stage.sv
// Input register for request transfers.
// Depends on wmpc_pkg.
`timescale 1ns / 1ps

module wmpc_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  wmpc_pkg::wmpc_req_type req_data,
   input  logic                  advance,
   output logic                  item_valid,
   output wmpc_pkg::wmpc_req_type item
);

   logic                   valid_ff;
   logic                   valid_in;
   wmpc_pkg::wmpc_req_type item_ff;
   logic                   load;

   assign req_stall  = valid_ff && !advance;
   assign load       = req_valid && !req_stall;
   assign valid_in   = load || (valid_ff && !advance);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_data;
      end
   end

endmodule

### rtl/wmpc_ctrl.sv
// Controller state and per-item decision logic, plus the timeout register.
// Depends on wmpc_pkg.
`timescale 1ns / 1ps

module wmpc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [23:0]            csr_data,
   input  logic                   advance,
   input  wmpc_pkg::wmpc_req_type item,
   output wmpc_pkg::wmpc_rsp_type result
);

   logic [23:0]          timeout_ff;
   logic [31:0]          time_ff, time_in;
   logic [31:0]          stop_ff, stop_in;
   logic [31:0]          calib_ff, calib_in;
   logic [23:0]          travel_ff, travel_in;
   logic [17:0]          travel_q_ff, travel_q_in;
   wmpc_pkg::phase_type  phase_ff, phase_in;
   wmpc_pkg::drive_type  drive_ff, drive_in;
   logic [6:0]           pos_ff, pos_in;
   logic                 known_ff, known_in;
   logic [6:0]           pending_ff, pending_in;

   logic        is_tick;
   logic [31:0] time_inc;
   logic [31:0] elapsed;
   logic        timed_out;
   logic [31:0] guard_stop;
   logic [6:0]  cmd_pct;
   logic [6:0]  st_pct;
   logic [6:0]  st_pos;
   logic        st_known;
   logic        st_up;
   logic        st_down;
   logic [6:0]  st_diff;
   logic [24:0] st_span;
   logic [31:0] st_base;
   logic [31:0] st_stop;
   logic        do_st;
   logic [31:0] cal_elapsed;
   logic [30:0] cal_half;
   logic [23:0] cal_travel;
   logic [48:0] cal_prod;

   assign is_tick    = (item.req_type == wmpc_pkg::REQ_TICK);
   assign time_inc   = time_ff + 32'd1;
   assign elapsed    = time_inc - stop_ff;
   assign timed_out  = !elapsed[31];
   assign guard_stop = time_ff + {8'd0, timeout_ff};

   // Set-target inputs: a command uses its own percent, the end of the first
   // close reuses the pending target from a known closed position.
   assign cmd_pct  = (item.target_percent > wmpc_pkg::PCT_FULL) ?
                     wmpc_pkg::PCT_FULL : item.target_percent;
   assign st_pct   = is_tick ? pending_ff : cmd_pct;
   assign st_pos   = is_tick ? wmpc_pkg::PCT_ZERO : pos_ff;
   assign st_known = is_tick || known_ff;
   assign st_up    = st_pct > st_pos;
   assign st_down  = st_pct < st_pos;
   assign st_diff  = st_up ? (st_pct - st_pos) : (st_pos - st_pct);
   assign st_span  = 25'(travel_q_ff) * 25'(st_diff);
   assign st_base  = is_tick ? time_inc : time_ff;
   assign st_stop  = st_base + {7'd0, st_span};

   assign cal_elapsed = time_inc - calib_ff;
   assign cal_half    = cal_elapsed[31:1];
   assign cal_travel  = (cal_half[30:24] != 7'd0) ? 24'hFFFFFF : cal_half[23:0];
   assign cal_prod    = 49'(cal_travel) * 49'(wmpc_pkg::DIV100_MAGIC);

   always_comb begin
      time_in     = time_ff;
      stop_in     = stop_ff;
      calib_in    = calib_ff;
      travel_in   = travel_ff;
      travel_q_in = travel_q_ff;
      phase_in    = phase_ff;
      drive_in    = drive_ff;
      pos_in      = pos_ff;
      known_in    = known_ff;
      pending_in  = pending_ff;
      do_st       = 1'b0;

      unique case (item.req_type)
         wmpc_pkg::REQ_TICK: begin
            time_in = time_inc;
            unique case (phase_ff)
               wmpc_pkg::PH_OPEN: begin
                  if (item.open_switch || timed_out) begin
                     phase_in = wmpc_pkg::PH_IDLE;
                     drive_in = wmpc_pkg::DRV_RELEASE;
                     pos_in   = item.open_switch ? wmpc_pkg::PCT_FULL : pending_ff;
                     known_in = 1'b1;
                  end
               end
               wmpc_pkg::PH_CLOSE: begin
                  if (item.close_switch || timed_out) begin
                     phase_in = wmpc_pkg::PH_IDLE;
                     drive_in = wmpc_pkg::DRV_RELEASE;
                     pos_in   = item.close_switch ? wmpc_pkg::PCT_ZERO : pending_ff;
                     known_in = 1'b1;
                  end
               end
               wmpc_pkg::PH_INIT_CLOSE: begin
                  if (timed_out) begin
                     drive_in = wmpc_pkg::DRV_RELEASE;
                     phase_in = wmpc_pkg::PH_ERROR;
                  end else if (item.close_switch) begin
                     pos_in   = wmpc_pkg::PCT_ZERO;
                     known_in = 1'b1;
                     phase_in = wmpc_pkg::PH_IDLE;
                     drive_in = wmpc_pkg::DRV_RELEASE;
                     do_st    = 1'b1;
                  end
               end
               wmpc_pkg::PH_CAL_CLOSE: begin
                  if (timed_out) begin
                     drive_in = wmpc_pkg::DRV_RELEASE;
                     phase_in = wmpc_pkg::PH_ERROR;
                  end else if (item.close_switch) begin
                     phase_in = wmpc_pkg::PH_CAL_OPEN;
                     if (!item.open_switch) begin
                        drive_in = wmpc_pkg::DRV_OPEN;
                     end
                  end
               end
               wmpc_pkg::PH_CAL_OPEN: begin
                  if (timed_out) begin
                     drive_in = wmpc_pkg::DRV_RELEASE;
                     phase_in = wmpc_pkg::PH_ERROR;
                  end else if (item.open_switch) begin
                     phase_in = wmpc_pkg::PH_CAL_RECLOSE;
                     if (!item.close_switch) begin
                        drive_in = wmpc_pkg::DRV_CLOSE;
                     end
                  end
               end
               wmpc_pkg::PH_CAL_RECLOSE: begin
                  if (timed_out) begin
                     drive_in = wmpc_pkg::DRV_RELEASE;
                     phase_in = wmpc_pkg::PH_ERROR;
                  end else if (item.close_switch) begin
                     travel_in   = cal_travel;
                     travel_q_in = cal_prod[wmpc_pkg::DIV100_SHIFT +: 18];
                     phase_in    = wmpc_pkg::PH_IDLE;
                     pos_in      = wmpc_pkg::PCT_ZERO;
                     known_in    = 1'b1;
                     drive_in    = wmpc_pkg::DRV_RELEASE;
                  end
               end
               default: begin
               end
            endcase
         end
         wmpc_pkg::REQ_SET_TGT: begin
            do_st = 1'b1;
         end
         wmpc_pkg::REQ_OPEN: begin
            stop_in    = guard_stop;
            phase_in   = wmpc_pkg::PH_OPEN;
            pending_in = wmpc_pkg::PCT_FULL;
            if (!item.open_switch) begin
               drive_in = wmpc_pkg::DRV_OPEN;
            end
         end
         wmpc_pkg::REQ_CLOSE: begin
            stop_in    = guard_stop;
            phase_in   = wmpc_pkg::PH_CLOSE;
            pending_in = wmpc_pkg::PCT_ZERO;
            if (!item.close_switch) begin
               drive_in = wmpc_pkg::DRV_CLOSE;
            end
         end
         wmpc_pkg::REQ_CALIBRATE: begin
            phase_in = wmpc_pkg::PH_CAL_CLOSE;
            stop_in  = guard_stop;
            calib_in = time_ff;
            if (!item.close_switch) begin
               drive_in = wmpc_pkg::DRV_CLOSE;
            end
         end
         default: begin
         end
      endcase

      if (do_st) begin
         priority if (!st_known) begin
            phase_in   = wmpc_pkg::PH_INIT_CLOSE;
            stop_in    = guard_stop;
            pending_in = st_pct;
            if (!item.close_switch) begin
               drive_in = wmpc_pkg::DRV_CLOSE;
            end
         end else if (st_up) begin
            stop_in    = st_stop;
            phase_in   = wmpc_pkg::PH_OPEN;
            pending_in = st_pct;
            if (!item.open_switch) begin
               drive_in = wmpc_pkg::DRV_OPEN;
            end
         end else if (st_down) begin
            stop_in    = st_stop;
            phase_in   = wmpc_pkg::PH_CLOSE;
            pending_in = st_pct;
            if (!item.close_switch) begin
               drive_in = wmpc_pkg::DRV_CLOSE;
            end
         end else begin
            // already at the target
         end
      end
   end

   always_comb begin
      result.motor_drive      = drive_in;
      result.position_percent = known_in ? pos_in : wmpc_pkg::PCT_ZERO;
      result.position_known   = known_in;
      result.phase            = phase_in;
      result.calibrating      = (phase_in == wmpc_pkg::PH_CAL_CLOSE) ||
                                (phase_in == wmpc_pkg::PH_CAL_OPEN) ||
                                (phase_in == wmpc_pkg::PH_CAL_RECLOSE);
      result.full_travel_ms   = travel_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= wmpc_pkg::TIMEOUT_RESET;
      end else if (csr_write) begin
         timeout_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff     <= '0;
         stop_ff     <= '0;
         calib_ff    <= '0;
         travel_ff   <= wmpc_pkg::TRAVEL_RESET;
         travel_q_ff <= wmpc_pkg::TRAVEL_Q_RESET;
         phase_ff    <= wmpc_pkg::PH_IDLE;
         drive_ff    <= wmpc_pkg::DRV_RELEASE;
         pos_ff      <= '0;
         known_ff    <= 1'b0;
         pending_ff  <= '0;
      end else if (advance) begin
         time_ff     <= time_in;
         stop_ff     <= stop_in;
         calib_ff    <= calib_in;
         travel_ff   <= travel_in;
         travel_q_ff <= travel_q_in;
         phase_ff    <= phase_in;
         drive_ff    <= drive_in;
         pos_ff      <= pos_in;
         known_ff    <= known_in;
         pending_ff  <= pending_in;
      end
   end

endmodule

### rtl/wmpc_out_stage.sv
// Result register for response transfers.
// Depends on wmpc_pkg.
`timescale 1ns / 1ps

module wmpc_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  wmpc_pkg::wmpc_rsp_type result,
   output logic                   can_load,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output wmpc_pkg::wmpc_rsp_type rsp_data
);

   logic                   valid_ff;
   logic                   valid_in;
   wmpc_pkg::wmpc_rsp_type data_ff;

   assign can_load  = !valid_ff || !rsp_stall;
   assign valid_in  = load || (valid_ff && rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

endmodule

### rtl/window_motor_position_controller.sv
// Window motor position controller: one request (1 ms tick or command) in, one
// status result out per transfer. Throughput is one request per clock while
// rsp_stall is low. A request passes the input register, the combinational
// decision logic and the result register. While a finished result waits on
// rsp_stall, no request advances, but an empty input register still takes one.
// The timeout register is written through csr_valid/csr_data and is always ready.
// Depends on wmpc_pkg, wmpc_in_stage, wmpc_ctrl, wmpc_out_stage.
`timescale 1ns / 1ps

module window_motor_position_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  wmpc_pkg::wmpc_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output wmpc_pkg::wmpc_rsp_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [23:0]            csr_data
);

   logic                   item_valid;
   wmpc_pkg::wmpc_req_type item;
   wmpc_pkg::wmpc_rsp_type result;
   logic                   can_load;
   logic                   advance;

   assign advance   = item_valid && can_load;
   assign csr_ready = 1'b1;

   wmpc_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   wmpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .advance   (advance),
      .item      (item),
      .result    (result)
   );

   wmpc_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result    (result),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### verif/tb.sv
// Self-checking bench for window_motor_position_controller: directed and random
// requests, a status predictor inside a small scoreboard class, random idle/stall.
// Depends on rtl/wmpc_pkg.sv and rtl/window_motor_position_controller.sv.
`timescale 1ns / 1ps

module tb;

   localparam logic [2:0] REQ_SPARE_5 = 3'd5;
   localparam logic [2:0] REQ_SPARE_6 = 3'd6;
   localparam logic [2:0] REQ_SPARE_7 = 3'd7;
   localparam logic [7:0] POS_UNKNOWN = 8'hFF;

   class motor_status_board;
      logic [23:0]            timeout_ms;
      logic [31:0]            now_ms;
      logic [31:0]            deadline_ms;
      logic [23:0]            travel;
      logic [31:0]            cal_start_ms;
      wmpc_pkg::phase_type    mode;
      logic [7:0]             pos;
      logic [7:0]             goal;
      wmpc_pkg::drive_type    motor;
      wmpc_pkg::wmpc_rsp_type status_due[$];
      int                     mismatches;
      int                     checked;
      int                     cal_done;
      int                     errors_entered;

      function new();
         timeout_ms = wmpc_pkg::TIMEOUT_RESET;
         now_ms = 0;
         deadline_ms = 0;
         travel = wmpc_pkg::TRAVEL_RESET;
         cal_start_ms = 0;
         mode = wmpc_pkg::PH_IDLE;
         pos = POS_UNKNOWN;
         goal = POS_UNKNOWN;
         motor = wmpc_pkg::DRV_RELEASE;
         mismatches = 0;
         checked = 0;
         cal_done = 0;
         errors_entered = 0;
      endfunction

      function void set_timeout(logic [23:0] value);
         timeout_ms = value;
      endfunction

      function void open_unless_at_end(bit sw);
         if (!sw) motor = wmpc_pkg::DRV_OPEN;
      endfunction

      function void close_unless_at_end(bit sw);
         if (!sw) motor = wmpc_pkg::DRV_CLOSE;
      endfunction

      function void abort_step();
         motor = wmpc_pkg::DRV_RELEASE;
         mode = wmpc_pkg::PH_ERROR;
         errors_entered++;
      endfunction

      function void aim(logic [7:0] pct, bit so, bit sc);
         logic [7:0]  p;
         logic [31:0] per_pct;
         logic [31:0] diff;
         p = (pct > 8'd100) ? 8'd100 : pct;
         per_pct = {8'd0, travel} / 32'd100;
         if (pos == POS_UNKNOWN) begin
            mode = wmpc_pkg::PH_INIT_CLOSE;
            close_unless_at_end(sc);
            deadline_ms = now_ms + {8'd0, timeout_ms};
            goal = p;
         end else if (p > pos) begin
            diff = 32'(p) - 32'(pos);
            deadline_ms = now_ms + per_pct * diff;
            mode = wmpc_pkg::PH_OPEN;
            open_unless_at_end(so);
            goal = p;
         end else if (p < pos) begin
            diff = 32'(pos) - 32'(p);
            deadline_ms = now_ms + per_pct * diff;
            mode = wmpc_pkg::PH_CLOSE;
            close_unless_at_end(sc);
            goal = p;
         end
      endfunction

      function void check_move(bit so, bit sc);
         logic [31:0] lag;
         logic [31:0] half;
         bit          expired;
         lag = now_ms - deadline_ms;
         expired = !lag[31];
         case (mode)
            wmpc_pkg::PH_OPEN: begin
               if (so || expired) begin
                  mode = wmpc_pkg::PH_IDLE;
                  motor = wmpc_pkg::DRV_RELEASE;
                  pos = so ? 8'd100 : goal;
               end
            end
            wmpc_pkg::PH_CLOSE: begin
               if (sc || expired) begin
                  mode = wmpc_pkg::PH_IDLE;
                  motor = wmpc_pkg::DRV_RELEASE;
                  pos = sc ? 8'd0 : goal;
               end
            end
            wmpc_pkg::PH_INIT_CLOSE: begin
               if (expired) begin
                  abort_step();
               end else if (sc) begin
                  pos = 8'd0;
                  mode = wmpc_pkg::PH_IDLE;
                  motor = wmpc_pkg::DRV_RELEASE;
                  aim(goal, so, sc);
               end
            end
            wmpc_pkg::PH_CAL_CLOSE: begin
               if (expired) begin
                  abort_step();
               end else if (sc) begin
                  mode = wmpc_pkg::PH_CAL_OPEN;
                  open_unless_at_end(so);
               end
            end
            wmpc_pkg::PH_CAL_OPEN: begin
               if (expired) begin
                  abort_step();
               end else if (so) begin
                  mode = wmpc_pkg::PH_CAL_RECLOSE;
                  close_unless_at_end(sc);
               end
            end
            wmpc_pkg::PH_CAL_RECLOSE: begin
               if (expired) begin
                  abort_step();
               end else if (sc) begin
                  half = (now_ms - cal_start_ms) / 32'd2;
                  travel = (half > 32'hFFFFFF) ? 24'hFFFFFF : half[23:0];
                  mode = wmpc_pkg::PH_IDLE;
                  pos = 8'd0;
                  motor = wmpc_pkg::DRV_RELEASE;
                  cal_done++;
               end
            end
            default: ;
         endcase
      endfunction

      function void apply_request(wmpc_pkg::wmpc_req_type r);
         wmpc_pkg::wmpc_rsp_type s;
         case (r.req_type)
            wmpc_pkg::REQ_TICK: begin
               now_ms = now_ms + 32'd1;
               check_move(r.open_switch, r.close_switch);
            end
            wmpc_pkg::REQ_SET_TGT: begin
               aim({1'b0, r.target_percent}, r.open_switch, r.close_switch);
            end
            wmpc_pkg::REQ_OPEN: begin
               deadline_ms = now_ms + {8'd0, timeout_ms};
               mode = wmpc_pkg::PH_OPEN;
               goal = 8'd100;
               open_unless_at_end(r.open_switch);
            end
            wmpc_pkg::REQ_CLOSE: begin
               deadline_ms = now_ms + {8'd0, timeout_ms};
               mode = wmpc_pkg::PH_CLOSE;
               goal = 8'd0;
               close_unless_at_end(r.close_switch);
            end
            wmpc_pkg::REQ_CALIBRATE: begin
               mode = wmpc_pkg::PH_CAL_CLOSE;
               deadline_ms = now_ms + {8'd0, timeout_ms};
               cal_start_ms = now_ms;
               close_unless_at_end(r.close_switch);
            end
            default: ;
         endcase
         s.motor_drive = motor;
         s.position_percent = (pos == POS_UNKNOWN) ? 7'd0 : pos[6:0];
         s.position_known = (pos != POS_UNKNOWN);
         s.phase = mode;
         s.calibrating = (mode == wmpc_pkg::PH_CAL_CLOSE || mode == wmpc_pkg::PH_CAL_OPEN ||
                          mode == wmpc_pkg::PH_CAL_RECLOSE);
         s.full_travel_ms = travel;
         status_due.push_back(s);
      endfunction

      function void check_status(wmpc_pkg::wmpc_rsp_type got);
         wmpc_pkg::wmpc_rsp_type want;
         if (status_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("error: status transfer with none expected: %h", got);
            return;
         end
         want = status_due.pop_front();
         checked++;
         if (got.motor_drive !== want.motor_drive ||
             got.position_percent !== want.position_percent ||
             got.position_known !== want.position_known ||
             got.phase !== want.phase ||
             got.calibrating !== want.calibrating ||
             got.full_travel_ms !== want.full_travel_ms) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("error: status %0d mismatch (drive pct known phase cal travel)", checked);
               $display("  expected %0d %0d %0d %0d %0d %0d", want.motor_drive,
                        want.position_percent, want.position_known, want.phase,
                        want.calibrating, want.full_travel_ms);
               $display("  actual   %0d %0d %0d %0d %0d %0d", got.motor_drive,
                        got.position_percent, got.position_known, got.phase,
                        got.calibrating, got.full_travel_ms);
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   wire                    req_stall;
   wmpc_pkg::wmpc_req_type req_data = '0;
   wire                    rsp_valid;
   logic                   rsp_stall = 1'b0;
   wmpc_pkg::wmpc_rsp_type rsp_data;
   logic                   csr_valid = 1'b0;
   wire                    csr_ready;
   logic [23:0]            csr_data = '0;

   motor_status_board board;
   bit  calm = 1'b0;
   int  sent = 0;
   int  settings = 0;

   window_motor_position_controller uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) board.check_status(rsp_data);
      rsp_stall <= !calm && ($urandom_range(99) < 17);
   end

   function automatic logic [6:0] rnd_pct();
      logic [6:0] v;
      if ($urandom_range(99) < 10) v = 7'($urandom_range(127, 101));
      else v = 7'($urandom_range(100));
      return v;
   endfunction

   task automatic push(input logic [2:0] kind, input logic [6:0] pct, input bit so,
                       input bit sc);
      wmpc_pkg::wmpc_req_type r;
      r.req_type = kind;
      r.target_percent = pct;
      r.open_switch = so;
      r.close_switch = sc;
      while (!calm && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.apply_request(r);
      sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (board.status_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [23:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      board.set_timeout(value);
      settings++;
   endtask

   // ticks with end switches hit now and then, toward the direction of travel
   task automatic ride_move(input int cap);
      int n;
      bit so;
      bit sc;
      n = 0;
      while (n < cap && board.mode inside {wmpc_pkg::PH_OPEN, wmpc_pkg::PH_CLOSE,
                                           wmpc_pkg::PH_INIT_CLOSE}) begin
         so = ($urandom_range(99) < 2);
         sc = ($urandom_range(99) < 2);
         if (board.mode == wmpc_pkg::PH_OPEN) so = ($urandom_range(99) < 4);
         else if (board.mode == wmpc_pkg::PH_CLOSE) sc = ($urandom_range(99) < 4);
         else sc = ($urandom_range(99) < 12);
         push(wmpc_pkg::REQ_TICK, rnd_pct(), so, sc);
         n++;
      end
   endtask

   // close, open, close legs; long legs give a travel time near 100 ms
   task automatic calibrate_run(input bit long_legs);
      int leg;
      int n;
      int len;
      push(wmpc_pkg::REQ_CALIBRATE, rnd_pct(), 1'($urandom_range(1)),
           $urandom_range(99) < 20);
      for (leg = 0; leg < 3; leg++) begin
         len = long_legs ? $urandom_range(75, 55) : $urandom_range(12);
         for (n = 0; n < len && board.mode != wmpc_pkg::PH_ERROR; n++)
            push(wmpc_pkg::REQ_TICK, rnd_pct(), 1'b0, 1'b0);
         if (board.mode != wmpc_pkg::PH_ERROR)
            push(wmpc_pkg::REQ_TICK, rnd_pct(), leg == 1, leg != 1);
      end
   endtask

   initial begin
      #5000000;
      $display("error: run timed out");
      $display("status: fail");
      $finish;
   end

   initial begin
      logic [23:0] timeout_plan [6];
      int          ph;
      int          quota;
      int          pick;
      timeout_plan = '{24'hFFFFFF, 24'd40, 24'd1, wmpc_pkg::TIMEOUT_RESET, 24'd150, 24'd9};
      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: unknown start, init close timeout, commands in error, ends
      write_timeout(24'd3);
      push(wmpc_pkg::REQ_TICK, 7'd0, 1'b0, 1'b0);
      push(REQ_SPARE_5, 7'h7F, 1'b1, 1'b1);
      push(REQ_SPARE_6, 7'h55, 1'b0, 1'b1);
      push(REQ_SPARE_7, 7'h2A, 1'b1, 1'b0);
      push(wmpc_pkg::REQ_SET_TGT, 7'd127, 1'b0, 1'b0);
      repeat (4) push(wmpc_pkg::REQ_TICK, 7'd0, 1'b0, 1'b0);
      push(wmpc_pkg::REQ_SET_TGT, 7'd50, 1'b0, 1'b1);
      push(wmpc_pkg::REQ_TICK, 7'd0, 1'b0, 1'b1);
      push(wmpc_pkg::REQ_OPEN, 7'd0, 1'b1, 1'b0);
      push(wmpc_pkg::REQ_TICK, 7'd0, 1'b1, 1'b0);
      push(wmpc_pkg::REQ_SET_TGT, 7'd100, 1'b1, 1'b0);
      push(wmpc_pkg::REQ_CLOSE, 7'd0, 1'b0, 1'b0);
      push(wmpc_pkg::REQ_TICK, 7'd0, 1'b0, 1'b1);
      push(wmpc_pkg::REQ_CALIBRATE, 7'd0, 1'b0, 1'b1);
      push(wmpc_pkg::REQ_TICK, 7'd0, 1'b0, 1'b1);
      push(wmpc_pkg::REQ_TICK, 7'd0, 1'b1, 1'b0);
      push(wmpc_pkg::REQ_TICK, 7'd0, 1'b0, 1'b1);
      push(wmpc_pkg::REQ_SET_TGT, 7'd40, 1'b0, 1'b0);
      push(wmpc_pkg::REQ_TICK, 7'd0, 1'b1, 1'b0);
      push(wmpc_pkg::REQ_SET_TGT, 7'd30, 1'b0, 1'b0);
      push(wmpc_pkg::REQ_TICK, 7'd0, 1'b0, 1'b0);
      write_timeout(24'd0);
      push(wmpc_pkg::REQ_CALIBRATE, 7'd0, 1'b0, 1'b0);
      push(wmpc_pkg::REQ_TICK, 7'd0, 1'b0, 1'b0);
      push(wmpc_pkg::REQ_OPEN, 7'd0, 1'b0, 1'b0);
      push(wmpc_pkg::REQ_TICK, 7'd0, 1'b0, 1'b0);

      for (ph = 0; ph < 6; ph++) begin
         write_timeout(timeout_plan[ph]);
         calm = (ph == 3);
         if (ph == 0 || ph == 3) calibrate_run(1'b1);
         quota = sent + 90;
         while (sent < quota) begin
            pick = $urandom_range(99);
            if ($urandom_range(99) < 3) drain_results();
            if (pick < 30) begin
               push(wmpc_pkg::REQ_SET_TGT, rnd_pct(), $urandom_range(99) < 8,
                    $urandom_range(99) < 8);
               ride_move(100);
            end else if (pick < 45) begin
               push(($urandom_range(1) != 0) ? wmpc_pkg::REQ_OPEN : wmpc_pkg::REQ_CLOSE,
                    rnd_pct(), $urandom_range(99) < 8, $urandom_range(99) < 8);
               ride_move(60);
            end else if (pick < 58) begin
               calibrate_run($urandom_range(99) < 25);
            end else if (pick < 72) begin
               repeat ($urandom_range(5, 1))
                  push(wmpc_pkg::REQ_TICK, rnd_pct(), $urandom_range(99) < 15,
                       $urandom_range(99) < 15);
            end else if (pick < 86) begin
               repeat ($urandom_range(6, 1))
                  push(3'($urandom_range(7)), rnd_pct(), 1'($urandom_range(1)),
                       1'($urandom_range(1)));
            end else begin
               push(wmpc_pkg::REQ_CALIBRATE, rnd_pct(), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
               repeat ($urandom_range(8))
                  push(wmpc_pkg::REQ_TICK, rnd_pct(), 1'($urandom_range(1)),
                       1'($urandom_range(1)));
            end
         end
      end
      calm = 1'b0;

      drain_results();
      repeat (8) @(posedge clock);
      $display("summary: %0d requests, %0d status transfers checked, %0d mismatches",
               sent, board.checked, board.mismatches);
      $display("summary: %0d calibrations finished, %0d error entries, %0d timeout settings",
               board.cal_done, board.errors_entered, settings);
      if (board.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/wmpc_pkg.sv
rtl/wmpc_in_stage.sv
rtl/wmpc_ctrl.sv
rtl/wmpc_out_stage.sv
rtl/window_motor_position_controller.sv
verif/tb.sv
